/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL. Define NO_ASSERTIONS to
// compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Expression holds at every clock edge out of reset.
`define ASSERT_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_HOLDS(label, clk, rst_n, expr)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/orm_pkg.sv */
// ----------------------------------------------------------------------------
// orm_pkg
// Types, constants and rounding helpers of the oscillation rotation matrix.
// ----------------------------------------------------------------------------
`default_nettype none

package orm_pkg;

    localparam int ANGLE_W       = 24;
    localparam int OUT_W         = 18;
    localparam int NUM_M         = 9;
    localparam int TDATA_IN_W    = 24;
    localparam int TDATA_OUT_W   = 168;
    localparam int PAD_W         = TDATA_OUT_W - NUM_M * OUT_W;
    localparam int FRAC_BITS_DEF = 16;

    // Angle to 32-bit phase: round(angle * 2^32 / (2*pi)) from Q5.18.
    localparam logic [37:0] PHASE_K  = 38'd174992710547;
    localparam int          PK_SPLIT = 19;
    localparam logic signed [19:0] PK_HI = 20'(PHASE_K >> PK_SPLIT);
    localparam logic signed [19:0] PK_LO = 20'(PHASE_K & ((38'd1 << PK_SPLIT) - 38'd1));
    localparam logic [57:0] PH_RND = 58'd1 << 25;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // Odd polynomial for sin(pi/2 * z), Q30.
    localparam logic signed [31:0] C1 = 32'sd1686629713;
    localparam logic signed [31:0] C3 = -32'sd693598668;
    localparam logic signed [31:0] C5 = 32'sd85569306;
    localparam logic signed [31:0] C7 = -32'sd5026995;
    localparam logic signed [31:0] C9 = 32'sd172272;
    localparam logic signed [31:0] HORNER_C [4] = '{C7, C5, C3, C1};

    typedef struct packed {
        logic       chi;   // item carries the tilt angle, not a request
        logic       last;
        logic [1:0] quad;
    } t_ctl;

    // Q30 product rounded to nearest, halves away from zero.
    function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd536870912;
        if (p < 0) begin
            s = s - 64'sd1;
        end
        return s[63:30];
    endfunction

endpackage

`default_nettype wire

/* sv/orm_ram.sv */
// ----------------------------------------------------------------------------
// orm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module orm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire [ADDR_W-1:0] i_waddr,
    input  wire [WIDTH-1:0]  i_wdata,
    input  wire              i_re,
    input  wire [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/oscillation_rotation_matrix.sv */
// ----------------------------------------------------------------------------
// oscillation_rotation_matrix
// Rotation matrix from an oscillation angle per request and a tilt angle.
// ----------------------------------------------------------------------------
// One request is taken per clock while the skid stage is empty and no tilt
// pass is pending; its matrix passes through the eighteen stages of the shared
// sine/cosine pipeline (phase multiply, two polynomial lanes of five
// multiply/round steps each, quadrant fold), the product stage and the output
// register. The tilt angle's sine and cosine go through the same pipeline as
// a request of their own and are kept in a one-entry RAM; the input is not
// ready after reset and after every write of the tilt register until that
// pass is launched. A two-entry output register and skid stage let the
// pipeline keep accepting while a result waits.
`default_nettype none
`include "assert_macros.svh"

module oscillation_rotation_matrix
    import orm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [ANGLE_W-1:0]      i_cfg_wdata,      // tilt_angle
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire [TDATA_IN_W-1:0]   s_axis_tdata,     // omega_angle
    input  wire                    s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,     // m00, m01, m02, m10, m11, m12,
                                                     // m20, m21, m22, zero pad
    output logic                   m_axis_tlast
);

    localparam int W     = FRAC_BITS + 2;
    localparam int SH    = 30 - FRAC_BITS;
    localparam int SH_M1 = (SH > 0) ? SH - 1 : 0;
    localparam logic [31:0] Q_RND = (SH > 0) ? (32'd1 << SH_M1) : 32'd0;
    localparam logic signed [2*W-1:0] P_RND = {{(2*W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [2*W-1:0] ONE_P = {{(2*W-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam int STAGES = 19;

    typedef logic signed [W-1:0] t_w;

    // Matrix product rounded to nearest, halves away from zero, clamped to +-1.0.
    function automatic t_w prod_clamp(input logic signed [2*W-1:0] pr);
        logic signed [2*W-1:0] s;
        logic signed [2*W-1:0] q;
        s = pr + P_RND;
        if (pr < 0) begin
            s = s - 1;
        end
        q = s >>> FRAC_BITS;
        if (q > ONE_P) begin
            q = ONE_P;
        end else if (q < -ONE_P) begin
            q = -ONE_P;
        end
        return W'(q);
    endfunction

    // Control
    logic [STAGES:1] r_v;
    t_ctl            r_ctl [1:STAGES];
    logic            r_chi_pend;
    logic signed [ANGLE_W-1:0] r_tilt;
    logic            r_out_v;
    logic            r_sk_v;
    logic            r_fwd_hit;

    // Datapath
    logic signed [ANGLE_W-1:0] r_ang;
    logic signed [43:0]        r_pp_hi;
    logic signed [43:0]        r_pp_lo;
    logic [31:0]               r_phase;
    logic [30:0]               r_z   [4:14][2];
    logic [61:0]               r_zz  [2];
    logic [30:0]               r_z2  [6:12][2];
    logic signed [63:0]        r_hm  [4][2];
    logic signed [31:0]        r_hp  [4][2];
    logic signed [63:0]        r_fm  [2];
    logic signed [33:0]        r_fp  [2];
    logic [FRAC_BITS:0]        r_f   [2];
    t_w                        r_s;
    t_w                        r_c;
    logic [2*W-1:0]            r_fwd_dat;
    t_w                        r_sw;
    t_w                        r_cw;
    t_w                        r_sc;
    t_w                        r_cc;
    logic signed [2*W-1:0]     r_pr  [4];
    logic [TDATA_OUT_W-1:0]    r_out;
    logic                      r_out_last;
    logic [TDATA_OUT_W-1:0]    r_sk;
    logic                      r_sk_last;

    logic                      w_en;
    logic                      w_take_in;
    logic                      w_out_free;
    logic                      w_res_v;
    logic [57:0]               w_ph_sum;
    logic signed [31:0]        w_hop [4][2];
    logic [30:0]               w_pcl [2];
    t_w                        w_fz;
    t_w                        w_fm;
    t_w                        n_s;
    t_w                        n_c;
    logic                      w_ram_we;
    logic [2*W-1:0]            w_ram_rd;
    logic [2*W-1:0]            w_chi_sc;
    t_w                        w_m10;
    t_w                        w_m12;
    t_w                        w_m20;
    t_w                        w_m22;
    logic [TDATA_OUT_W-1:0]    w_res;

    assign w_en          = ~r_sk_v;
    assign s_axis_tready = w_en & ~r_chi_pend;
    assign w_take_in     = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = ~r_out_v | m_axis_tready;
    assign w_res_v       = r_v[STAGES] & w_en;
    assign w_ram_we      = w_en & r_v[18] & r_ctl[18].chi;

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out;
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        w_ph_sum = (58'(r_pp_hi) <<< PK_SPLIT) + 58'(r_pp_lo) + PH_RND;
        for (int l = 0; l < 2; l++) begin
            w_hop[0][l] = C9;
            for (int k = 1; k < 4; k++) begin
                w_hop[k][l] = r_hp[k-1][l];
            end
            if (r_fp[l] < 0) begin
                w_pcl[l] = '0;
            end else if (r_fp[l] > $signed({3'b000, Q30_ONE})) begin
                w_pcl[l] = Q30_ONE;
            end else begin
                w_pcl[l] = r_fp[l][30:0];
            end
        end
    end

    // Fold the quarter-wave values into sine and cosine by quadrant.
    always_comb begin
        w_fz = t_w'({1'b0, r_f[0]});
        w_fm = t_w'({1'b0, r_f[1]});
        unique case (r_ctl[17].quad)
            2'd0: begin
                n_s = w_fz;
                n_c = w_fm;
            end
            2'd1: begin
                n_s = w_fm;
                n_c = -w_fz;
            end
            2'd2: begin
                n_s = -w_fz;
                n_c = -w_fm;
            end
            default: begin
                n_s = -w_fm;
                n_c = w_fz;
            end
        endcase
    end

    // A tilt write lands in the same cycle the following request reads it.
    assign w_chi_sc = r_fwd_hit ? r_fwd_dat : w_ram_rd;

    always_comb begin
        w_m10 = prod_clamp(r_pr[0]);
        w_m12 = -prod_clamp(r_pr[1]);
        w_m20 = -prod_clamp(r_pr[2]);
        w_m22 = prod_clamp(r_pr[3]);
        w_res = {{PAD_W{1'b0}},
                 OUT_W'(w_m22), OUT_W'(r_sc), OUT_W'(w_m20),
                 OUT_W'(w_m12), OUT_W'(r_cc), OUT_W'(w_m10),
                 OUT_W'(r_sw), {OUT_W{1'b0}}, OUT_W'(r_cw)};
    end

    orm_ram #(
        .WIDTH (2 * W),
        .DEPTH (1)
    ) u_chi_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (1'b0),
        .i_wdata ({r_s, r_c}),
        .i_re    (w_en),
        .i_raddr (1'b0),
        .o_rdata (w_ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v        <= '0;
            r_chi_pend <= 1'b1;
            r_tilt     <= '0;
            r_out_v    <= 1'b0;
            r_sk_v     <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tilt <= i_cfg_wdata;
            end
            if (i_cfg_we) begin
                r_chi_pend <= 1'b1;
            end else if (w_en) begin
                r_chi_pend <= 1'b0;
            end
            if (w_en) begin
                r_v       <= {r_v[18] & ~r_ctl[18].chi, r_v[17:1], w_take_in | r_chi_pend};
                r_fwd_hit <= w_ram_we & r_v[17] & ~r_ctl[17].chi;
            end
            if (w_out_free) begin
                if (r_sk_v) begin
                    r_out_v <= 1'b1;
                    r_sk_v  <= 1'b0;
                end else begin
                    r_out_v <= w_res_v;
                end
            end else if (w_res_v) begin
                r_sk_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ang    <= r_chi_pend ? r_tilt : s_axis_tdata;
            r_ctl[1] <= '{chi: r_chi_pend, last: s_axis_tlast & ~r_chi_pend, quad: 2'd0};
            // The quadrant joins the control word once the phase is known.
            for (int s = 2; s <= STAGES; s++) begin
                if (s == 4) begin
                    r_ctl[s] <= '{chi: r_ctl[3].chi, last: r_ctl[3].last,
                                  quad: r_phase[31:30]};
                end else begin
                    r_ctl[s] <= r_ctl[s-1];
                end
            end

            r_pp_hi <= r_ang * PK_HI;
            r_pp_lo <= r_ang * PK_LO;
            r_phase <= w_ph_sum[57:26];

            r_z[4][0] <= {1'b0, r_phase[29:0]};
            r_z[4][1] <= Q30_ONE - {1'b0, r_phase[29:0]};
            for (int s = 5; s <= 14; s++) begin
                r_z[s] <= r_z[s-1];
            end
            for (int s = 7; s <= 12; s++) begin
                r_z2[s] <= r_z2[s-1];
            end

            for (int l = 0; l < 2; l++) begin
                r_zz[l]    <= r_z[4][l] * r_z[4][l];
                r_z2[6][l] <= 31'((r_zz[l] + 62'd536870912) >> 30);
                for (int k = 0; k < 4; k++) begin
                    r_hm[k][l] <= w_hop[k][l] * $signed({1'b0, r_z2[6+2*k][l]});
                    r_hp[k][l] <= HORNER_C[k] + 32'(rnd30(r_hm[k][l]));
                end
                r_fm[l] <= r_hp[3][l] * $signed({1'b0, r_z[14][l]});
                r_fp[l] <= rnd30(r_fm[l]);
                r_f[l]  <= (FRAC_BITS + 1)'(({1'b0, w_pcl[l]} + Q_RND) >> SH);
            end

            r_s       <= n_s;
            r_c       <= n_c;
            r_fwd_dat <= {r_s, r_c};

            r_sw  <= r_s;
            r_cw  <= r_c;
            r_sc  <= w_chi_sc[2*W-1:W];
            r_cc  <= w_chi_sc[W-1:0];
            r_pr[0] <= $signed(w_chi_sc[2*W-1:W]) * r_s;
            r_pr[1] <= $signed(w_chi_sc[2*W-1:W]) * r_c;
            r_pr[2] <= $signed(w_chi_sc[W-1:0]) * r_s;
            r_pr[3] <= $signed(w_chi_sc[W-1:0]) * r_c;
        end

        if (w_out_free) begin
            if (r_sk_v) begin
                r_out      <= r_sk;
                r_out_last <= r_sk_last;
            end else begin
                r_out      <= w_res;
                r_out_last <= r_ctl[STAGES].last;
            end
        end else if (w_res_v) begin
            r_sk      <= w_res;
            r_sk_last <= r_ctl[STAGES].last;
        end
    end

    `ASSERT_HOLDS(a_skid_needs_out, i_clk, i_rst_n, !r_sk_v || r_out_v)
    `ASSERT_NEXT(a_cfg_queues_chi, i_clk, i_rst_n, i_cfg_we, r_chi_pend)
    `ASSERT_IMPL(a_no_input_while_chi, i_clk, i_rst_n, r_chi_pend, !s_axis_tready)
    `ASSERT_IMPL(a_fwd_only_request, i_clk, i_rst_n, r_fwd_hit, r_v[18] && !r_ctl[18].chi)
    `ASSERT_IMPL(a_m01_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[2*OUT_W-1:OUT_W] == '0)

endmodule

`default_nettype wire
